@@ src/route_table_best_path_update_assert.svh @@
// Assertion macros for the route table best-path update block.
// Included by the top level, which checks its own control logic.
`ifndef ROUTE_TABLE_BEST_PATH_UPDATE_ASSERT_SVH
`define ROUTE_TABLE_BEST_PATH_UPDATE_ASSERT_SVH
// An implication that must hold at every clock edge outside reset.
`define RT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table check failed");
// An implication whose consequent is checked in the cycle after its antecedent.
`define RT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table check failed");
`endif

@@ src/rtbp_pkg.sv @@
// Shared types and constants for the route table best-path update block.
// No dependencies.
package rtbp_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int NUM_CELLS = 4;
  localparam int SEG_DEPTH = TABLE_ENTRIES / NUM_CELLS;
  localparam int SEG_W = $clog2(SEG_DEPTH);
  localparam int CELL_W = $clog2(NUM_CELLS);

  localparam logic CMD_ANNOUNCE = 1'b0;
  localparam logic CMD_WITHDRAW = 1'b1;

  localparam logic [2:0] OUT_INSERTED   = 3'd0;
  localparam logic [2:0] OUT_REPLACED   = 3'd1;
  localparam logic [2:0] OUT_KEPT       = 3'd2;
  localparam logic [2:0] OUT_WITHDRAWN  = 3'd3;
  localparam logic [2:0] OUT_WD_IGNORED = 3'd4;
  localparam logic [2:0] OUT_FULL       = 3'd5;

  typedef struct packed {
    logic        command;
    logic [31:0] prefix_addr;
    logic [5:0]  prefix_len;
    logic [31:0] peer_addr;
    logic [31:0] next_hop_addr;
    logic [7:0]  path_length;
    logic        origin_igp;
    logic [30:0] exit_metric;
  } update_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [9:0]  slot;
    logic [10:0] entries_used;
  } result_t;

  typedef struct packed {
    logic [31:0] peer;
    logic [31:0] hop_addr;
    logic [7:0]  path_length;
    logic        igp;
    logic [30:0] metric;
  } route_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match;
    route_t            route;
    logic              have_free;
    logic [SLOT_W-1:0] free_slot;
  } search_t;

  // Write command broadcast from the controller to all cells.
  typedef struct packed {
    logic              wr;
    logic              set_valid;
    logic              clr_valid;
    logic [SLOT_W-1:0] slot;
  } cell_wr_t;

  function automatic logic new_wins(route_t old_r, update_t u);
    if (u.path_length != old_r.path_length) return u.path_length < old_r.path_length;
    if (u.origin_igp != old_r.igp) return !u.origin_igp;
    if (u.exit_metric != old_r.metric) return u.exit_metric < old_r.metric;
    return u.next_hop_addr < old_r.hop_addr;
  endfunction
endpackage

@@ src/rtbp_cell.sv @@
// One table segment of the route table search chain.
// Depends on rtbp_pkg.
module rtbp_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      scan,
  input  logic                      clear,
  input  logic [rtbp_pkg::SEG_W-1:0] scan_idx,
  input  logic [rtbp_pkg::CELL_W-1:0] cell_id,
  input  rtbp_pkg::update_t         key,
  input  rtbp_pkg::search_t         tok_in,
  output rtbp_pkg::search_t         tok_out,
  input  rtbp_pkg::cell_wr_t        wr,
  input  rtbp_pkg::update_t         wr_data
);
  import rtbp_pkg::*;

  logic        valid    [SEG_DEPTH];
  logic [31:0] mem_addr [SEG_DEPTH];
  logic [5:0]  mem_len  [SEG_DEPTH];
  route_t      mem_rt   [SEG_DEPTH];

  logic [31:0] rd_addr;
  logic [5:0]  rd_len;
  route_t      rd_rt;
  logic        rd_valid;
  logic        rd_live;
  logic [SLOT_W-1:0] rd_slot;
  search_t     tok_next;
  logic        wr_here;
  logic [SEG_W-1:0] wr_idx;

  assign wr_here = (wr.slot[SLOT_W-1 -: CELL_W] == cell_id);
  assign wr_idx  = wr.slot[SEG_W-1:0];

  // Registered memory read, one entry per cycle.
  always_ff @(posedge clk) begin
    rd_addr <= mem_addr[scan_idx];
    rd_len  <= mem_len[scan_idx];
    rd_rt   <= mem_rt[scan_idx];
    rd_slot <= {cell_id, scan_idx};
    if (wr.wr && wr_here) begin
      mem_addr[wr_idx] <= wr_data.prefix_addr;
      mem_len[wr_idx]  <= wr_data.prefix_len;
      mem_rt[wr_idx]   <= '{peer: wr_data.peer_addr, hop_addr: wr_data.next_hop_addr,
                            path_length: wr_data.path_length, igp: wr_data.origin_igp,
                            metric: wr_data.exit_metric};
    end
  end

  // Valid bits are a memory of their own; the clearing pass writes one address a cycle.
  always_ff @(posedge clk) begin
    rd_valid <= valid[scan_idx];
    if (clear) valid[scan_idx] <= 1'b0;
    else if (wr_here && wr.set_valid) valid[wr_idx] <= 1'b1;
    else if (wr_here && wr.clr_valid) valid[wr_idx] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live  <= scan;
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (rd_live) begin
      if (rd_valid) begin
        if (!tok_in.found && rd_addr == key.prefix_addr && rd_len == key.prefix_len) begin
          tok_next.found = 1'b1;
          tok_next.match = rd_slot;
          tok_next.route = rd_rt;
        end
      end else if (!tok_in.have_free) begin
        tok_next.have_free = 1'b1;
        tok_next.free_slot = rd_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end
endmodule

@@ src/route_table_best_path_update.sv @@
// Top level of the route table best-path update block: controller and cell chain.
// Depends on rtbp_pkg, rtbp_cell and route_table_best_path_update_assert.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------
//   update   | start, busy        | update (update_t)
//   result   | done (one cycle)   | result (result_t)
//
// An update word is taken when start is high and busy is low. The table is split
// into NUM_CELLS segments; every cycle each cell reads one entry and hands its
// search token on, so all segments are swept in lock step and the tokens then
// pass out through the rest of the chain. A merge register at the chain's end
// keeps the match and the lowest free slot. After reset a clearing pass zeroes
// the valid bits, with busy held high. The receiver cannot stall: the result
// word is shown on the done cycle only.
module route_table_best_path_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rtbp_pkg::update_t update,
  output logic              done,
  output rtbp_pkg::result_t result
);
  import rtbp_pkg::*;
`include "route_table_best_path_update_assert.svh"

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  update_t key;
  logic [SEG_W:0] cnt;
  logic [CNT_W-1:0] used_count;
  search_t tok [NUM_CELLS+1];
  cell_wr_t wr;
  logic scan;
  logic clearing;
  logic [SEG_W-1:0] scan_idx;
  search_t fin;
  search_t acc, acc_next;
  logic [2:0] oc;
  logic [SLOT_W-1:0] oslot;
  logic [CNT_W-1:0] used_next;

  assign busy = (state != ST_IDLE);
  assign scan = (state == ST_SCAN);
  assign clearing = (state == ST_CLEAR);
  assign scan_idx = cnt[SEG_W-1:0];
  assign tok[0] = '0;
  assign fin = tok[NUM_CELLS];

  // The chain: cell k covers slots k*SEG_DEPTH onward; the token moves right.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rtbp_cell u_cell (
      .clk(clk), .rst(rst), .scan(scan), .clear(clearing), .scan_idx(scan_idx),
      .cell_id(CELL_W'(k)), .key(key), .tok_in(tok[k]), .tok_out(tok[k+1]),
      .wr(wr), .wr_data(key)
    );
  end

  // Each token leaving the chain covers at most one entry per segment. Keys are unique in
  // the table, so any match is the match; the free slot kept is the lowest seen.
  always_comb begin
    acc_next = acc;
    if (fin.found && !acc.found) begin
      acc_next.found = 1'b1;
      acc_next.match = fin.match;
      acc_next.route = fin.route;
    end
    if (fin.have_free && (!acc.have_free || fin.free_slot < acc.free_slot)) begin
      acc_next.have_free = 1'b1;
      acc_next.free_slot = fin.free_slot;
    end
    if (start && !busy) acc_next = '0;
  end

  // Decide the outcome once the last token has been merged.
  always_comb begin
    wr = '0;
    oc = OUT_WD_IGNORED;
    oslot = '0;
    used_next = used_count;
    if (key.command == CMD_ANNOUNCE) begin
      if (acc.found) begin
        oslot = acc.match;
        if (new_wins(acc.route, key)) begin
          oc = OUT_REPLACED;
          wr = '{wr: 1'b1, set_valid: 1'b1, clr_valid: 1'b0, slot: acc.match};
        end else begin
          oc = OUT_KEPT;
        end
      end else if (acc.have_free) begin
        oc = OUT_INSERTED;
        oslot = acc.free_slot;
        used_next = used_count + CNT_W'(1);
        wr = '{wr: 1'b1, set_valid: 1'b1, clr_valid: 1'b0, slot: acc.free_slot};
      end else begin
        oc = OUT_FULL;
      end
    end else if (acc.found) begin
      oslot = acc.match;
      if (acc.route.peer == key.peer_addr) begin
        oc = OUT_WITHDRAWN;
        if (used_count != '0) used_next = used_count - CNT_W'(1);
        wr = '{wr: 1'b0, set_valid: 1'b0, clr_valid: 1'b1, slot: acc.match};
      end
    end
    if (state != ST_DONE) wr = '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (cnt == (SEG_W+1)'(SEG_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (cnt == (SEG_W+1)'(SEG_DEPTH - 1)) state_next = ST_DRAIN;
      ST_DRAIN: if (cnt == (SEG_W+1)'(NUM_CELLS)) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) key <= update;
    acc <= acc_next;
    result <= '{outcome: oc, slot: 10'(oslot), entries_used: 11'(used_next)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      used_count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + (SEG_W+1)'(1);
      if (state == ST_DONE) used_count <= used_next;
    end
  end

  `RT_ASSERT_IMP(a_busy_on_done, done, !busy)
  `RT_ASSERT_NEXT(a_done_after, state == ST_DONE, done)
  `RT_ASSERT_IMP(a_count_range, 1'b1, used_count <= CNT_W'(TABLE_ENTRIES))
  `RT_ASSERT_IMP(a_write_only_done, wr.wr || wr.clr_valid, state == ST_DONE)
endmodule

@@ verif/route_table_best_path_update_tb.sv @@
// Self-checking testbench for the route table best-path update block.
// Depends on rtbp_pkg and the route_table_best_path_update top level.
module route_table_best_path_update_tb;
  import rtbp_pkg::*;

  localparam int UPDATE_CYCLES = SEG_DEPTH + NUM_CELLS + 3;
  localparam int RANDOM_WORDS = 560;
  localparam int DRAIN_CYCLES = 2 * UPDATE_CYCLES;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  update_t update;
  logic    done;
  result_t result;

  // The predictor keeps its own copy of the table.
  logic              tbl_valid [TABLE_ENTRIES];
  logic [31:0]       tbl_addr  [TABLE_ENTRIES];
  logic [5:0]        tbl_len   [TABLE_ENTRIES];
  route_t            tbl_route [TABLE_ENTRIES];
  int unsigned       tbl_count;

  // Expected result words; new ones enter at the front, the oldest leaves at the back.
  result_t pending_results [$];
  int      error_count;

  // Prefixes that are known to be in use, so that later updates hit them.
  logic [31:0] live_addr [$];
  logic [5:0]  live_len  [$];
  logic [31:0] live_peer [$];

  route_table_best_path_update dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .update (update),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Returns true when the announced route beats the one already stored.
  function automatic logic announce_beats(route_t stored, update_t u);
    if (u.path_length != stored.path_length) return u.path_length < stored.path_length;
    if (u.origin_igp != stored.igp) return u.origin_igp == 1'b0;
    if (u.exit_metric != stored.metric) return u.exit_metric < stored.metric;
    return u.next_hop_addr < stored.hop_addr;
  endfunction

  // Applies one update word to the table copy and gives the result it must produce.
  function automatic result_t apply_update(update_t u);
    result_t r;
    logic    found;
    logic    have_free;
    int      hit;
    int      free_idx;
    route_t  nr;
    found = 1'b0;
    have_free = 1'b0;
    hit = 0;
    free_idx = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (!found && tbl_addr[i] == u.prefix_addr && tbl_len[i] == u.prefix_len) begin
          found = 1'b1;
          hit = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx = i;
      end
    end
    nr.peer = u.peer_addr;
    nr.hop_addr = u.next_hop_addr;
    nr.path_length = u.path_length;
    nr.igp = u.origin_igp;
    nr.metric = u.exit_metric;
    r.slot = '0;
    if (u.command == CMD_ANNOUNCE) begin
      if (found) begin
        r.slot = hit[9:0];
        if (announce_beats(tbl_route[hit], u)) begin
          tbl_route[hit] = nr;
          r.outcome = OUT_REPLACED;
        end else begin
          r.outcome = OUT_KEPT;
        end
      end else if (have_free) begin
        tbl_valid[free_idx] = 1'b1;
        tbl_addr[free_idx] = u.prefix_addr;
        tbl_len[free_idx] = u.prefix_len;
        tbl_route[free_idx] = nr;
        tbl_count++;
        r.slot = free_idx[9:0];
        r.outcome = OUT_INSERTED;
      end else begin
        r.outcome = OUT_FULL;
      end
    end else begin
      if (found) begin
        r.slot = hit[9:0];
        if (tbl_route[hit].peer == u.peer_addr) begin
          tbl_valid[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
          r.outcome = OUT_WITHDRAWN;
        end else begin
          r.outcome = OUT_WD_IGNORED;
        end
      end else begin
        r.outcome = OUT_WD_IGNORED;
      end
    end
    r.entries_used = tbl_count[10:0];
    return r;
  endfunction

  // Each result word is on the port for one cycle only, so it is checked at that edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_back();
        if (result.outcome !== want.outcome)
          report_mismatch("outcome", 32'(result.outcome), 32'(want.outcome));
        if (result.slot !== want.slot)
          report_mismatch("slot", 32'(result.slot), 32'(want.slot));
        if (result.entries_used !== want.entries_used)
          report_mismatch("entries_used", 32'(result.entries_used),
                          32'(want.entries_used));
      end
    end
  end

  // Sender gaps are mostly short, now and then long, and sometimes absent.
  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: n = 0;
      9: n = $urandom_range(20, 300);
      default: n = $urandom_range(1, 6);
    endcase
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Presents one word and holds start until the block takes it. The prediction
  // is made at the accepting edge, when the word's order in the table is fixed.
  // Start stays high afterwards until a gap, a pause or the next word replaces it.
  task automatic send_update(update_t u, logic check_typed, result_t typed);
    result_t r;
    update <= u;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_update(u);
    pending_results.push_front(r);
    if (check_typed && r !== typed)
      report_mismatch("directed row", 32'(r), 32'(typed));
    if (u.command == CMD_ANNOUNCE && r.outcome == OUT_INSERTED) begin
      live_addr.insert(live_addr.size(), u.prefix_addr);
      live_len.insert(live_len.size(), u.prefix_len);
      live_peer.insert(live_peer.size(), u.peer_addr);
    end
  endtask

  function automatic update_t make_update(logic cmd, logic [31:0] addr, logic [5:0] len,
                                          logic [31:0] peer, logic [31:0] nh,
                                          logic [7:0] plen, logic igp, logic [30:0] med);
    update_t u;
    u.command = cmd;
    u.prefix_addr = addr;
    u.prefix_len = len;
    u.peer_addr = peer;
    u.next_hop_addr = nh;
    u.path_length = plen;
    u.origin_igp = igp;
    u.exit_metric = med;
    return u;
  endfunction

  // A mostly well-formed random update: either on a live prefix or on a fresh one.
  function automatic update_t random_update();
    update_t u;
    int      k;
    u = make_update($urandom_range(0, 3) == 0 ? CMD_WITHDRAW : CMD_ANNOUNCE,
                    $urandom(), 6'($urandom_range(0, 32)), $urandom(), $urandom(),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    31'($urandom()));
    if ($urandom_range(0, 19) == 0) u.prefix_len = 6'($urandom_range(33, 63));
    if ($urandom_range(0, 9) == 0) u.exit_metric = '1;
    if (live_addr.size() > 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, live_addr.size() - 1);
      u.prefix_addr = live_addr[k];
      u.prefix_len = live_len[k];
      // Most withdraws here come from the peer that first stored the route.
      if (u.command == CMD_WITHDRAW && $urandom_range(0, 3) != 0) u.peer_addr = live_peer[k];
      // Narrow the attributes so that the later tie-breaks are reached.
      u.path_length = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) u.exit_metric = 31'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) u.next_hop_addr = $urandom_range(0, 3);
    end
    return u;
  endfunction

  typedef struct {
    update_t u;
    logic    typed;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic void add_row(update_t u, logic typed, logic [2:0] outcome,
                                  logic [9:0] slot, logic [10:0] used);
    stim_row_t row;
    row.u = u;
    row.typed = typed;
    row.want.outcome = outcome;
    row.want.slot = slot;
    row.want.entries_used = used;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  initial begin
    int          sent;
    logic [31:0] one32;
    one32 = '1;
    rst <= 1'b1;
    start <= 1'b0;
    update <= '0;
    error_count = 0;
    tbl_count = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;

    // Directed rows: table extremes, every outcome but OUT_FULL, and each tie-break step.
    add_row(make_update(CMD_WITHDRAW, 32'h0, 6'd0, 32'h0, 32'h0, 8'd0, 1'b0, '0),
            1'b1, OUT_WD_IGNORED, 10'd0, 11'd0);
    add_row(make_update(CMD_ANNOUNCE, 32'h0, 6'd0, 32'h0, 32'h0, 8'd0, 1'b0, '0),
            1'b1, OUT_INSERTED, 10'd0, 11'd1);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd63, one32, one32, 8'd255, 1'b1, '1),
            1'b1, OUT_INSERTED, 10'd1, 11'd2);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, one32, one32, 8'd255, 1'b1, '1),
            1'b1, OUT_INSERTED, 10'd2, 11'd3);
    // Shorter path, then the non-IGP origin, then lower metric, then lower next hop.
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h1, one32, 8'd254, 1'b1, '1),
            1'b1, OUT_REPLACED, 10'd2, 11'd3);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h2, one32, 8'd254, 1'b0, '1),
            1'b1, OUT_REPLACED, 10'd2, 11'd3);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h3, one32, 8'd254, 1'b1, '0),
            1'b1, OUT_KEPT, 10'd2, 11'd3);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h4, one32, 8'd254, 1'b0, 31'd5),
            1'b1, OUT_REPLACED, 10'd2, 11'd3);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h5, 32'h7fff_ffff, 8'd254, 1'b0,
            31'd5), 1'b1, OUT_REPLACED, 10'd2, 11'd3);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h6, 32'h7fff_ffff, 8'd254, 1'b0,
            31'd5), 1'b1, OUT_KEPT, 10'd2, 11'd3);
    add_row(make_update(CMD_ANNOUNCE, one32, 6'd32, 32'h7, 32'h8000_0000, 8'd0, 1'b0,
            31'd5), 1'b1, OUT_REPLACED, 10'd2, 11'd3);
    // Withdraw from another peer is ignored; from the storing peer it erases.
    add_row(make_update(CMD_WITHDRAW, one32, 6'd32, 32'h6, 32'h0, 8'd0, 1'b0, '0),
            1'b1, OUT_WD_IGNORED, 10'd2, 11'd3);
    add_row(make_update(CMD_WITHDRAW, one32, 6'd32, 32'h7, 32'h0, 8'd0, 1'b0, '0),
            1'b1, OUT_WITHDRAWN, 10'd2, 11'd2);
    add_row(make_update(CMD_WITHDRAW, 32'h0, 6'd0, 32'h0, 32'h0, 8'd0, 1'b0, '0),
            1'b1, OUT_WITHDRAWN, 10'd0, 11'd1);
    // A new prefix reuses the lowest free slot.
    add_row(make_update(CMD_ANNOUNCE, 32'h0a00_0000, 6'd8, 32'h0, 32'h0, 8'd3, 1'b1, '0),
            1'b1, OUT_INSERTED, 10'd0, 11'd2);
    add_row(make_update(CMD_ANNOUNCE, 32'h0a00_0000, 6'd9, 32'h0, 32'h0, 8'd3, 1'b1, '0),
            1'b0, '0, '0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_update(directed_rows[i].u, directed_rows[i].typed, directed_rows[i].want);
      idle_gap();
    end

    for (sent = 0; sent < RANDOM_WORDS; sent++) begin
      send_update(random_update(), 1'b0, '0);
      if (sent % 100 < 20) idle_gap();
      if (sent == RANDOM_WORDS / 2) begin
        // Hold off until every outstanding word has been seen.
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("route_table_best_path_update_tb OK");
    else
      $display("route_table_best_path_update_tb NOT OK");
    $finish;
  end

  // About 580 words plus their gaps stay well inside this limit.
  initial begin
    #(4 * 2_000_000);
    $display("route_table_best_path_update_tb NOT OK");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/rtbp_pkg.sv
src/rtbp_cell.sv
src/route_table_best_path_update.sv
verif/route_table_best_path_update_tb.sv
